>>> rtl/utf8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared types and constants of the UTF-8 / UCS-2 transcoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

    localparam int unsigned UNIT_W    = 16;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned Q_DEPTH   = 2;

    // direction register codes
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // register index
    localparam logic REG_DIRECTION = 1'b0;

    // decode state: continuation bytes still awaited
    localparam logic [1:0] EXP_NONE = 2'd0;
    localparam logic [1:0] EXP_ONE  = 2'd1;
    localparam logic [1:0] EXP_TWO  = 2'd2;

    // last-result index of a job
    localparam logic [1:0] LAST_FIRST  = 2'd0;
    localparam logic [1:0] LAST_SECOND = 2'd1;
    localparam logic [1:0] LAST_THIRD  = 2'd2;

    localparam logic [7:0] MASK_F0   = 8'hf0;
    localparam logic [7:0] MASK_E0   = 8'he0;
    localparam logic [7:0] MASK_C0   = 8'hc0;
    localparam logic [7:0] MASK_F8   = 8'hf8;
    localparam logic [7:0] HI_SURR   = 8'hd8;
    localparam logic [7:0] SURR_B0   = 8'hed;
    localparam logic [7:0] SURR_B1   = 8'h9f;
    localparam logic [7:0] SURR_B2   = 8'hbf;
    localparam logic [7:0] MASK_3F   = 8'h3f;
    localparam logic [7:0] CONT_80   = 8'h80;

    typedef struct packed {
        logic [UNIT_W-1:0] data_in;
        logic              end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [UNIT_W-1:0] value_out;
        logic              last_of_run;
        logic              short_sequence;
    } t_out_item;

    // one accepted item's worth of results, handed from front to back
    typedef struct packed {
        logic [MAX_RES-1:0][UNIT_W-1:0] value;
        logic [1:0]                     last_idx;
        logic                           short_seq;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

>>> rtl/utf8_ucs2_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// A beat's first result passes the job queue, then the output register.
// Throughput: 1 beat per cycle when decoding, while the queue is not full;
// an encode unit gives 1 to 3 beats, one per UTF-8 byte, from the back end.
// Reset (i_rst_n low, synchronous): direction returns to decode, decode
// state, job queue and output register are emptied.
// ----------------------------------------------------------------------------
// utf8_ucs2_transcoder
// Two-way UTF-8 / UCS-2 converter with an APB direction register.
// ----------------------------------------------------------------------------
module utf8_ucs2_transcoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire utf8_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output utf8_pkg::t_out_item      o_out_data
);

    logic                r_dir;
    logic                cfg_wr;
    logic                push, pop;
    utf8_pkg::t_job      job_in, job_out;
    utf8_pkg::t_q_status q_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == utf8_pkg::REG_DIRECTION);
    assign prdata = (paddr[2] == utf8_pkg::REG_DIRECTION) ? {31'd0, r_dir} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= utf8_pkg::DIR_DECODE;
        end else if (cfg_wr) begin
            r_dir <= pwdata[0];
        end
    end

    utf8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dir       (r_dir),
        .i_state_clr (cfg_wr),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_job       (job_in)
    );

    utf8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_job    (job_out),
        .o_status (q_status)
    );

    utf8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_out),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule
`default_nettype wire

>>> rtl/utf8_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_front
// Accepts input beats, runs the UTF-8 decode state and builds result jobs.
// ----------------------------------------------------------------------------
module utf8_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_dir,
    input  wire logic                i_state_clr,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire utf8_pkg::t_in_item  i_item,
    input  wire utf8_pkg::t_q_status i_q_status,
    output logic                     o_push,
    output utf8_pkg::t_job           o_job
);

    logic [1:0] r_exp, n_exp;
    logic [9:0] r_part, n_part;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  hi, lo;
    logic [15:0] acc;
    logic        done;
    logic [15:0] dec_value;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign b       = i_item.data_in[7:0];
    assign hi      = i_item.data_in[15:8];
    assign lo      = i_item.data_in[7:0];
    assign acc     = {r_part, b[5:0]};

    always_comb begin
        n_exp     = r_exp;
        n_part    = r_part;
        done      = 1'b0;
        dec_value = '0;
        if (r_exp == utf8_pkg::EXP_NONE) begin
            if ((b & utf8_pkg::MASK_F0) == utf8_pkg::MASK_E0) begin
                n_part = {6'd0, b[3:0]};
                n_exp  = utf8_pkg::EXP_TWO;
            end else if ((b & utf8_pkg::MASK_E0) == utf8_pkg::MASK_C0) begin
                n_part = {5'd0, b[4:0]};
                n_exp  = utf8_pkg::EXP_ONE;
            end else begin
                dec_value = {8'd0, b};
                done      = 1'b1;
            end
        end else if (r_exp == utf8_pkg::EXP_ONE) begin
            dec_value = acc;
            n_exp     = utf8_pkg::EXP_NONE;
            n_part    = '0;
            done      = 1'b1;
        end else begin
            n_part = acc[9:0];
            n_exp  = utf8_pkg::EXP_ONE;
        end
        if (i_item.end_of_input) begin
            n_exp  = utf8_pkg::EXP_NONE;
            n_part = '0;
        end
    end

    always_comb begin
        o_job = '0;
        if (i_dir == utf8_pkg::DIR_DECODE) begin
            o_push         = accept && (done || i_item.end_of_input);
            o_job.last_idx = utf8_pkg::LAST_FIRST;
            // cut-short sequence: single zero result flagged short
            o_job.value[0]  = done ? dec_value : '0;
            o_job.short_seq = !done;
        end else begin
            o_push = accept;
            if ((hi & utf8_pkg::MASK_F8) == utf8_pkg::HI_SURR) begin
                o_job.value[0] = {8'd0, utf8_pkg::SURR_B0};
                o_job.value[1] = {8'd0, utf8_pkg::SURR_B1};
                o_job.value[2] = {8'd0, utf8_pkg::SURR_B2};
                o_job.last_idx = utf8_pkg::LAST_THIRD;
            end else if ((hi & utf8_pkg::MASK_F8) != 8'd0) begin
                o_job.value[0] = {8'd0, utf8_pkg::MASK_E0 | {4'd0, hi[7:4]}};
                o_job.value[1] = {8'd0, utf8_pkg::CONT_80 | {2'd0, hi[3:0], lo[7:6]}};
                o_job.value[2] = {8'd0, utf8_pkg::CONT_80 | (lo & utf8_pkg::MASK_3F)};
                o_job.last_idx = utf8_pkg::LAST_THIRD;
            end else if ((hi != 8'd0) || lo[7]) begin
                o_job.value[0] = {8'd0, utf8_pkg::MASK_C0 | {3'd0, hi[2:0], lo[7:6]}};
                o_job.value[1] = {8'd0, utf8_pkg::CONT_80 | (lo & utf8_pkg::MASK_3F)};
                o_job.last_idx = utf8_pkg::LAST_SECOND;
            end else begin
                o_job.value[0] = {8'd0, lo};
                o_job.last_idx = utf8_pkg::LAST_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_state_clr) begin
            r_exp  <= utf8_pkg::EXP_NONE;
            r_part <= '0;
        end else if (accept && (i_dir == utf8_pkg::DIR_DECODE)) begin
            r_exp  <= n_exp;
            r_part <= n_part;
        end
    end

endmodule
`default_nettype wire

>>> rtl/utf8_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module utf8_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire utf8_pkg::t_job      i_job,
    input  wire logic                i_pop,
    output utf8_pkg::t_job           o_job,
    output utf8_pkg::t_q_status      o_status
);

    utf8_pkg::t_job r_mem [utf8_pkg::Q_DEPTH];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_status.full  = (r_cnt == 2'(utf8_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == 2'd0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/utf8_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_back
// Walks the results of the head job into the output register, one a beat.
// ----------------------------------------------------------------------------
module utf8_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire utf8_pkg::t_job      i_job,
    input  wire utf8_pkg::t_q_status i_q_status,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output utf8_pkg::t_out_item      o_item
);

    logic [1:0]          r_idx;
    logic                r_valid;
    utf8_pkg::t_out_item r_item;
    logic                load, is_last;

    assign load    = !i_q_status.empty && (!r_valid || i_ready);
    assign is_last = (r_idx == i_job.last_idx);
    assign o_pop   = load && is_last;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.value_out      <= i_job.value[r_idx];
            r_item.last_of_run    <= is_last;
            r_item.short_sequence <= i_job.short_seq;
        end
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 / UCS-2 transcoder: directed corner
// sequences in both directions, then mostly well-formed random UTF-8 runs and
// random code units, with bursty input beats and a stalling result sink.
// ----------------------------------------------------------------------------
module testbench;
    import utf8_pkg::*;

    localparam logic [2:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
    localparam logic [2:0] ADDR_SPARE     = 3'd4;   // no register behind it
    localparam int         DRAIN_PAD      = 6;
    localparam int         QUIET_LIMIT    = 1000;
    localparam int         PRINT_CAP      = 40;

    // ------------------------------------------------------------------------
    // expected-result store with its own copy of the conversion state
    // ------------------------------------------------------------------------
    class transcode_board;
        logic        dir;
        logic [1:0]  need;          // continuation bytes still awaited
        logic [9:0]  partial;
        t_out_item   awaited_results[$];
        int          errors, n_dec, n_enc, n_checked, n_short, n_surr;

        function new();
            dir = DIR_DECODE;
            need = EXP_NONE;
            partial = '0;
        endfunction

        task report_mismatch(input string msg);
            if (errors < PRINT_CAP)
                $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function void set_direction(input logic d);
            dir = d;
            need = EXP_NONE;
            partial = '0;
        endfunction

        function void push(input logic [15:0] v, input logic last, input logic sh);
            t_out_item r;
            r.value_out = v;
            r.last_of_run = last;
            r.short_sequence = sh;
            awaited_results.push_back(r);
        endfunction

        // works out the beats one input item causes
        function void transcode_item(input t_in_item it);
            logic [7:0]  b, hi, lo;
            logic [15:0] acc;
            logic        done;
            done = 1'b0;
            if (dir == DIR_DECODE) begin
                n_dec++;
                b = it.data_in[7:0];
                if (need == EXP_NONE) begin
                    if (b[7:4] == 4'he) begin
                        partial = {6'd0, b[3:0]};
                        need = EXP_TWO;
                    end else if (b[7:5] == 3'b110) begin
                        partial = {5'd0, b[4:0]};
                        need = EXP_ONE;
                    end else begin
                        push({8'd0, b}, 1'b1, 1'b0);
                        done = 1'b1;
                    end
                end else begin
                    // any byte inside a sequence counts as a continuation
                    acc = {partial, b[5:0]};
                    if (need == EXP_ONE) begin
                        push(acc, 1'b1, 1'b0);
                        need = EXP_NONE;
                        partial = '0;
                        done = 1'b1;
                    end else begin
                        partial = acc[9:0];
                        need = EXP_ONE;
                    end
                end
                if (it.end_of_input) begin
                    if (!done) begin
                        push(16'd0, 1'b1, 1'b1);
                        n_short++;
                    end
                    need = EXP_NONE;
                    partial = '0;
                end
            end else begin
                n_enc++;
                hi = it.data_in[15:8];
                lo = it.data_in[7:0];
                if (hi[7:3] == 5'b11011) begin
                    n_surr++;
                    push(16'h00ed, 1'b0, 1'b0);
                    push(16'h009f, 1'b0, 1'b0);
                    push(16'h00bf, 1'b1, 1'b0);
                end else if (hi[7:3] != 5'd0) begin
                    push({8'd0, 4'he, hi[7:4]}, 1'b0, 1'b0);
                    push({8'd0, 2'b10, hi[3:0], lo[7:6]}, 1'b0, 1'b0);
                    push({8'd0, 2'b10, lo[5:0]}, 1'b1, 1'b0);
                end else if (hi != 8'd0 || lo[7]) begin
                    push({8'd0, 3'b110, hi[2:0], lo[7:6]}, 1'b0, 1'b0);
                    push({8'd0, 2'b10, lo[5:0]}, 1'b1, 1'b0);
                end else begin
                    push({8'd0, lo}, 1'b1, 1'b0);
                end
            end
        endfunction

        function void note_item(input t_in_item it);
            transcode_item(it);
        endfunction

        task check_result(input t_out_item got);
            t_out_item want;
            n_checked++;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat value=%h last=%b short=%b",
                    got.value_out, got.last_of_run, got.short_sequence));
            end else begin
                want = awaited_results.pop_front();
                if (got.value_out !== want.value_out ||
                    got.last_of_run !== want.last_of_run ||
                    got.short_sequence !== want.short_sequence)
                    report_mismatch($sformatf(
                        "beat %0d: value %h/%h last %b/%b short %b/%b (got/exp)",
                        n_checked, got.value_out, want.value_out, got.last_of_run,
                        want.last_of_run, got.short_sequence, want.short_sequence));
            end
        endtask

        task flush_leftovers();
            t_out_item want;
            while (awaited_results.size() != 0) begin
                want = awaited_results.pop_front();
                report_mismatch($sformatf("missing beat value=%h last=%b short=%b",
                    want.value_out, want.last_of_run, want.short_sequence));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    in_data   = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_item   o_out_data;

    transcode_board board = new();
    int          burst_left = 0;
    int          cfg_writes = 0;
    int          quiet = 0;
    int          rx_cycle = 0;

    utf8_ucs2_transcoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result sink: checks each beat, stall pattern cycles through four modes
    always @(posedge i_clk) begin
        int mode;
        mode = (rx_cycle / 150) % 4;
        rx_cycle++;
        if (i_rst_n && o_out_valid && out_ready)
            board.check_result(o_out_data);
        case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 99) < 75);
            2: out_ready <= ($urandom_range(0, 99) < 35);
            default: out_ready <= (rx_cycle[2:0] != 3'd0);
        endcase
    end

    // watchdog: consecutive cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles", QUIET_LIMIT);
            $display("utf8_ucs2_transcoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [15:0] d, input logic eoi);
        t_in_item it;
        int gap;
        it.data_in = d;
        it.end_of_input = eoi;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(it);
    endtask

    // lowers valid, waits for every awaited beat, then lets the pipe settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (board.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_DIRECTION)
            board.set_direction(val[0]);
        cfg_writes++;
    endtask

    // one UTF-8 run: single byte, noise, or a 2/3-byte sequence, sometimes broken
    task automatic send_utf8_run(output int beats);
        logic [7:0] seq [3];
        int kind, len;
        kind = $urandom_range(0, 99);
        len = 1;
        if (kind < 15) begin
            seq[0] = 8'($urandom_range(0, 255));
        end else if (kind < 35) begin
            case ($urandom_range(0, 2))
                0: seq[0] = 8'($urandom_range(8'h00, 8'h7f));
                1: seq[0] = 8'($urandom_range(8'h80, 8'hbf));
                default: seq[0] = 8'($urandom_range(8'hf0, 8'hff));
            endcase
        end else if (kind < 65) begin
            seq[0] = 8'hc0 | 8'($urandom_range(0, 31));
            seq[1] = 8'h80 | 8'($urandom_range(0, 63));
            len = 2;
        end else begin
            seq[0] = 8'he0 | 8'($urandom_range(0, 15));
            seq[1] = 8'h80 | 8'($urandom_range(0, 63));
            seq[2] = 8'h80 | 8'($urandom_range(0, 63));
            len = 3;
        end
        if (len > 1 && $urandom_range(0, 9) == 0)
            seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++)
            send_item({8'($urandom_range(0, 255)), seq[i]}, $urandom_range(0, 19) == 0);
        beats = len;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    logic [16:0] enc_corners [10] = '{
        {16'h0000, 1'b0}, {16'h007f, 1'b1}, {16'h0080, 1'b0}, {16'h07ff, 1'b0},
        {16'h0800, 1'b1}, {16'hd7ff, 1'b0}, {16'hd800, 1'b0}, {16'hdfff, 1'b1},
        {16'he000, 1'b0}, {16'hffff, 1'b0}
    };

    initial begin
        int n, beats;
        logic phase_dir;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // decode corners
        reg_write(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        send_item(16'h0000, 1'b0);
        send_item(16'hff7f, 1'b0);          // high byte ignored
        send_item(16'h0080, 1'b0);          // stray continuation passes through
        send_item(16'h00ff, 1'b0);
        send_item(16'h00df, 1'b0);
        send_item(16'h00bf, 1'b0);
        send_item(16'h00e2, 1'b0);
        send_item(16'h0082, 1'b0);
        send_item(16'h00ac, 1'b0);
        send_item(16'h00ef, 1'b0);
        send_item(16'h00bf, 1'b0);
        send_item(16'h00bf, 1'b0);
        send_item(16'h00e4, 1'b0);          // leads inside a sequence
        send_item(16'h00c5, 1'b0);
        send_item(16'h00f3, 1'b0);
        send_item(16'h00c3, 1'b1);          // stream ends on a lead
        send_item(16'h00e5, 1'b0);
        send_item(16'h0088, 1'b1);          // stream ends mid three-byte
        send_item(16'h00c3, 1'b0);
        send_item(16'h00a9, 1'b1);
        send_item(16'h0041, 1'b1);
        // direction write drops a half-done sequence
        send_item(16'h00e2, 1'b0);
        wait_drain();
        reg_write(ADDR_DIRECTION, {31'd0, DIR_DECODE});
        send_item(16'h0082, 1'b0);
        // write to an unmapped address leaves the sequence alone
        send_item(16'h00c3, 1'b0);
        wait_drain();
        reg_write(ADDR_SPARE, 32'hffff_ffff);
        send_item(16'h00a9, 1'b0);
        wait_drain();

        // encode corners
        reg_write(ADDR_DIRECTION, {31'd0, DIR_ENCODE});
        foreach (enc_corners[i])
            send_item(enc_corners[i][16:1], enc_corners[i][0]);

        // random phases, alternating direction
        for (int ph = 0; ph < 6; ph++) begin
            wait_drain();
            phase_dir = (ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE;
            reg_write(ADDR_DIRECTION, {31'($urandom), phase_dir});
            n = 0;
            while (n < 58) begin
                if (n >= 32 && n < 35)
                    wait_drain();
                if (phase_dir == DIR_DECODE) begin
                    send_utf8_run(beats);
                    n += beats;
                end else begin
                    case ($urandom_range(0, 4))
                        0: send_item(16'($urandom_range(16'h0000, 16'h007f)), 1'b0);
                        1: send_item(16'($urandom_range(16'h0080, 16'h07ff)), 1'b0);
                        2: send_item(16'($urandom_range(16'hd800, 16'hdfff)), 1'b0);
                        default: send_item(16'($urandom_range(0, 16'hffff)),
                                           $urandom_range(0, 9) == 0);
                    endcase
                    n++;
                end
            end
        end

        wait_drain();
        repeat (DRAIN_PAD) @(posedge i_clk);
        board.flush_leftovers();
        $display("run: %0d UTF-8 bytes decoded, %0d UCS-2 units encoded, %0d beats checked",
            board.n_dec, board.n_enc, board.n_checked);
        $display("run: %0d cut-short sequences, %0d surrogate units, %0d register writes",
            board.n_short, board.n_surr, cfg_writes);
        if (board.errors == 0)
            $display("utf8_ucs2_transcoder: match");
        else
            $display("utf8_ucs2_transcoder: mismatch");
        $finish;
    end
endmodule
